/* hw/rtl/spq_pkg.sv */
// Shared types, codes and default sizes of the sorted priority queue.
package spq_pkg;

	localparam int DEPTH_DEF          = 16;
	localparam int VALUE_WIDTH_DEF    = 8;
	localparam int PRIORITY_WIDTH_DEF = 16;
	localparam int OCC_WIDTH          = 5;

	localparam logic ACTION_ENQ = 1'b0;
	localparam logic ACTION_DEQ = 1'b1;

	// Commands from the controller to the datapath for one accepted transfer.
	typedef struct packed {
		logic load;
		logic enq;
		logic deq;
		logic reject;
	} spq_cmd_t;

	// Status of the entry array seen by the controller.
	typedef struct packed {
		logic full;
		logic empty;
	} spq_status_t;

endpackage

/* hw/rtl/spq_ctrl.sv */
// Controller of the sorted priority queue: handshake and command decode.
module spq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 action,
	output logic                 res_valid,
	input  logic                 res_stall,
	input  spq_pkg::spq_status_t status,
	output spq_pkg::spq_cmd_t    cmd
);
	import spq_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_HOLD
	} state_t;

	state_t state_q;
	logic   accept;

	// A new transfer may enter whenever the result register is free or is being taken.
	assign in_stall  = (state_q == S_HOLD) && res_stall;
	assign accept    = in_valid && !in_stall;
	assign res_valid = (state_q == S_HOLD);

	always_comb begin
		cmd.load   = accept;
		cmd.enq    = accept && (action == ACTION_ENQ) && !status.full;
		cmd.reject = accept && (action == ACTION_ENQ) && status.full;
		cmd.deq    = accept && (action == ACTION_DEQ) && !status.empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (accept) state_q <= S_HOLD;
					else if (!res_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A result that is waiting and stalled must not be overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |-> !cmd.load)
		else $error("result overwritten while stalled");

	// An enqueue is either stored or refused, never both.
	a_enq_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.enq && cmd.reject))
		else $error("enqueue both stored and refused");

	// Every accepted transfer leaves a result on the output side.
	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> res_valid)
		else $error("accepted transfer produced no result");

endmodule

/* hw/rtl/spq_datapath.sv */
// Datapath of the sorted priority queue: sorted entry cells and result registers.
module spq_datapath #(
	parameter int DEPTH          = spq_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH    = spq_pkg::VALUE_WIDTH_DEF,
	parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  spq_pkg::spq_cmd_t            cmd,
	output spq_pkg::spq_status_t         status,
	input  logic [VALUE_WIDTH-1:0]       value,
	input  logic [PRIORITY_WIDTH-1:0]    priority_req,
	output logic [VALUE_WIDTH-1:0]       out_value,
	output logic [PRIORITY_WIDTH-1:0]    out_priority,
	output logic                         out_valid,
	output logic                         rejected,
	output logic [spq_pkg::OCC_WIDTH-1:0] occupancy,
	output logic                         is_empty
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [VALUE_WIDTH-1:0]    val_q [DEPTH];
	logic [PRIORITY_WIDTH-1:0] pri_q [DEPTH];
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_d;
	logic [DEPTH-1:0]          ge;

	logic [VALUE_WIDTH-1:0]    out_value_q;
	logic [PRIORITY_WIDTH-1:0] out_priority_q;
	logic                      out_valid_q;
	logic                      rejected_q;
	logic [OCC_WIDTH-1:0]      occupancy_q;
	logic                      is_empty_q;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);

	// Stored entries whose priority is not below the new one; they move up one cell.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ge[i] = (count_q > CNT_W'(i)) && (pri_q[i] >= priority_req);
		end
	end

	always_comb begin
		count_d = count_q;
		if (cmd.enq) count_d = count_q + 1'b1;
		else if (cmd.deq) count_d = count_q - 1'b1;
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic from_below;
		logic take_new;
		if (g == 0) begin : g_head
			assign from_below = 1'b0;
		end else begin : g_body
			assign from_below = ge[g-1];
		end
		assign take_new = (ge[g] || (count_q == CNT_W'(g))) && !from_below;

		always_ff @(posedge clk) begin
			if (cmd.deq) begin
				if (g < DEPTH - 1) begin
					val_q[g] <= val_q[(g + 1) % DEPTH];
					pri_q[g] <= pri_q[(g + 1) % DEPTH];
				end
			end else if (cmd.enq) begin
				if (from_below) begin
					val_q[g] <= val_q[(g + DEPTH - 1) % DEPTH];
					pri_q[g] <= pri_q[(g + DEPTH - 1) % DEPTH];
				end else if (take_new) begin
					val_q[g] <= value;
					pri_q[g] <= priority_req;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_value_q    <= cmd.deq ? val_q[0] : '0;
			out_priority_q <= cmd.deq ? pri_q[0] : '0;
			out_valid_q    <= cmd.deq;
			rejected_q     <= cmd.reject;
			occupancy_q    <= OCC_WIDTH'(count_d);
			is_empty_q     <= (count_d == '0);
		end
	end

	assign out_value    = out_value_q;
	assign out_priority = out_priority_q;
	assign out_valid    = out_valid_q;
	assign rejected     = rejected_q;
	assign occupancy    = occupancy_q;
	assign is_empty     = is_empty_q;

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.enq && cmd.deq))
		else $error("enqueue and dequeue in the same cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq |=> (count_q - $past(count_q)) == CNT_W'(1))
		else $error("enqueue did not add one entry");

	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.deq |=> ($past(count_q) - count_q) == CNT_W'(1))
		else $error("dequeue did not remove one entry");

endmodule

/* hw/rtl/sorted_priority_queue_top.sv */
// Top level of the sorted priority queue: controller and datapath.
//
// Usage: one input channel (in_valid / in_stall) carries items with fields
// action, value and priority_req. Action ENQ stores the value in priority
// order; smaller priorities leave first, and a new entry goes ahead of
// stored entries of equal priority. Action DEQ removes the head entry.
// Each accepted input transfer produces exactly one result transfer on the
// output channel (res_valid / res_stall) with the dequeued entry, a refusal
// flag for an enqueue into a full queue, the occupancy and an empty flag.
// The result is valid in the cycle after the input transfer. Throughput is
// one item per cycle unless the receiver stalls: all cells compare against
// the new priority and shift in parallel within the cycle that accepts it.
// A waiting result sits in the output register; while the receiver stalls
// it, a new input is stalled as well, and input is taken again in the cycle
// in which the held result is transferred.
// Reset empties the queue at once and clears res_valid; no clearing
// sweep is needed, since cells beyond the occupancy are never observed.
module sorted_priority_queue_top #(
	parameter int DEPTH          = spq_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH    = spq_pkg::VALUE_WIDTH_DEF,
	parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [VALUE_WIDTH-1:0]        value,
	input  logic [PRIORITY_WIDTH-1:0]     priority_req,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [VALUE_WIDTH-1:0]        out_value,
	output logic [PRIORITY_WIDTH-1:0]     out_priority,
	output logic                          out_valid,
	output logic                          rejected,
	output logic [spq_pkg::OCC_WIDTH-1:0] occupancy,
	output logic                          is_empty
);
	import spq_pkg::*;

	// Commands for the accepted transfer and the fill state of the entry array.
	spq_cmd_t    cmd;
	spq_status_t status;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the sorted entries and the registered result fields.
	spq_datapath #(
		.DEPTH          (DEPTH),
		.VALUE_WIDTH    (VALUE_WIDTH),
		.PRIORITY_WIDTH (PRIORITY_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.value        (value),
		.priority_req (priority_req),
		.out_value    (out_value),
		.out_priority (out_priority),
		.out_valid    (out_valid),
		.rejected     (rejected),
		.occupancy    (occupancy),
		.is_empty     (is_empty)
	);

endmodule

/* tb/sv/spq_checker.sv */
`timescale 1ns / 1ps
// Checker for the sorted priority queue: tracks the queue contents and compares every result.
module spq_checker #(
	parameter int DEPTH          = spq_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH    = spq_pkg::VALUE_WIDTH_DEF,
	parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          action,
	input  logic [VALUE_WIDTH-1:0]        value,
	input  logic [PRIORITY_WIDTH-1:0]     priority_req,
	input  logic                          res_valid,
	input  logic                          res_stall,
	input  logic [VALUE_WIDTH-1:0]        out_value,
	input  logic [PRIORITY_WIDTH-1:0]     out_priority,
	input  logic                          out_valid,
	input  logic                          rejected,
	input  logic [spq_pkg::OCC_WIDTH-1:0] occupancy,
	input  logic                          is_empty,
	output int                            fail_count,
	output int                            pending
);

	typedef struct packed {
		logic [VALUE_WIDTH-1:0]        value;
		logic [PRIORITY_WIDTH-1:0]     prio;
		logic                          valid;
		logic                          rejected;
		logic [spq_pkg::OCC_WIDTH-1:0] occupancy;
		logic                          empty;
	} queue_result_t;

	logic [VALUE_WIDTH-1:0]    held_value [DEPTH];
	logic [PRIORITY_WIDTH-1:0] held_prio  [DEPTH];
	int                        held_count  = 0;
	int                        error_count = 0;
	queue_result_t             awaited_results [$];

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	// Applies one accepted item to the tracked contents and queues its result.
	task automatic apply_item(input logic act, input logic [VALUE_WIDTH-1:0] val,
			input logic [PRIORITY_WIDTH-1:0] prio);
		queue_result_t res;
		int            pos;
		res = '0;
		if (act == spq_pkg::ACTION_ENQ) begin
			if (held_count >= DEPTH) begin
				res.rejected = 1'b1;
			end else begin
				// The new entry goes ahead of every entry whose priority is not smaller.
				pos = 0;
				while (pos < held_count && held_prio[pos] < prio)
					pos++;
				for (int i = held_count; i > pos; i--) begin
					held_value[i] = held_value[i-1];
					held_prio[i]  = held_prio[i-1];
				end
				held_value[pos] = val;
				held_prio[pos]  = prio;
				held_count++;
			end
		end else if (held_count > 0) begin
			res.value = held_value[0];
			res.prio  = held_prio[0];
			res.valid = 1'b1;
			for (int i = 0; i + 1 < held_count; i++) begin
				held_value[i] = held_value[i+1];
				held_prio[i]  = held_prio[i+1];
			end
			held_count--;
		end
		res.occupancy = spq_pkg::OCC_WIDTH'(held_count);
		res.empty     = (held_count == 0);
		awaited_results.push_back(res);
	endtask

	task automatic check_result();
		queue_result_t want;
		if (awaited_results.size() == 0) begin
			report_mismatch("result transfer with no item waiting for it");
		end else begin
			want = awaited_results.pop_front();
			if (out_value !== want.value)
				report_mismatch($sformatf("out_value %0h, want %0h", out_value, want.value));
			if (out_priority !== want.prio)
				report_mismatch($sformatf("out_priority %0h, want %0h",
					out_priority, want.prio));
			if (out_valid !== want.valid)
				report_mismatch($sformatf("out_valid %b, want %b", out_valid, want.valid));
			if (rejected !== want.rejected)
				report_mismatch($sformatf("rejected %b, want %b", rejected, want.rejected));
			if (occupancy !== want.occupancy)
				report_mismatch($sformatf("occupancy %0d, want %0d",
					occupancy, want.occupancy));
			if (is_empty !== want.empty)
				report_mismatch($sformatf("is_empty %b, want %b", is_empty, want.empty));
		end
	endtask

	// A result is checked before the item of the same edge is applied, since that
	// item's result cannot leave before the next edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			awaited_results.delete();
			pending    <= 0;
			fail_count <= error_count;
		end else begin
			if (res_valid && !res_stall)
				check_result();
			if (in_valid && !in_stall)
				apply_item(action, value, priority_req);
			pending    <= awaited_results.size();
			fail_count <= error_count;
		end
	end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the sorted priority queue: stimulus, idling, and the verdict.
module tb;

	localparam int VW = spq_pkg::VALUE_WIDTH_DEF;
	localparam int PW = spq_pkg::PRIORITY_WIDTH_DEF;

	// This limit leaves a wide margin for the slowest correct run, with the heaviest
	// idling, over about 850 items.
	localparam int CYCLE_LIMIT     = 200000;
	localparam int HOLD_OFF_CYCLES = 60;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          in_valid     = 1'b0;
	logic                          in_stall;
	logic                          action       = spq_pkg::ACTION_ENQ;
	logic [VW-1:0]                 value        = '0;
	logic [PW-1:0]                 priority_req = '0;
	logic                          res_valid;
	logic                          res_stall    = 1'b0;
	logic [VW-1:0]                 out_value;
	logic [PW-1:0]                 out_priority;
	logic                          out_valid;
	logic                          rejected;
	logic [spq_pkg::OCC_WIDTH-1:0] occupancy;
	logic                          is_empty;

	int fail_count;
	int pending;
	int cycle_count   = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off_req  = 1'b0;

	sorted_priority_queue_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.value        (value),
		.priority_req (priority_req),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.out_value    (out_value),
		.out_priority (out_priority),
		.out_valid    (out_valid),
		.rejected     (rejected),
		.occupancy    (occupancy),
		.is_empty     (is_empty)
	);

	// The checker watches both channels beside the block and reports its count of
	// failures and the number of results still owed.
	spq_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.value        (value),
		.priority_req (priority_req),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.out_value    (out_value),
		.out_priority (out_priority),
		.out_valid    (out_valid),
		.rejected     (rejected),
		.occupancy    (occupancy),
		.is_empty     (is_empty),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The run is cut off here if the block stops moving transfers.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver side. It stalls at random with the current idle rate. Once the
	// hold-off is requested it keeps the result channel stalled for a long stretch,
	// so the held result blocks the output register and the block has to stall its
	// input while the sender keeps offering items.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_done) begin
				res_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				res_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Offers one item, starting and ending at a falling edge. Random idle cycles
	// come first; once valid is raised the payload holds until the transfer.
	// Valid is only ever lowered in an idle cycle, so it is never lowered and
	// raised at the same edge.
	task automatic send_item(input logic act, input logic [VW-1:0] val,
			input logic [PW-1:0] prio);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		value        <= val;
		priority_req <= prio;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// Priorities lean toward a few small numbers so that equal priorities are
	// common, with the extremes and fully random numbers mixed in.
	function automatic logic [PW-1:0] pick_priority();
		case ($urandom_range(3))
			0: begin
				return PW'($urandom_range(7));
			end
			1: begin
				return $urandom_range(1) ? '1 : '0;
			end
			default: begin
				return PW'($urandom);
			end
		endcase
	endfunction

	// Random items in bursts: some bursts mostly insert and drive the queue to
	// full, some mostly remove and drain it past empty, others stay balanced.
	task automatic send_random(input int count);
		int enq_pct;
		int left_in_burst;
		enq_pct       = 50;
		left_in_burst = 0;
		repeat (count) begin
			if (left_in_burst == 0) begin
				case ($urandom_range(2))
					0: begin
						enq_pct = 85;
					end
					1: begin
						enq_pct = 20;
					end
					default: begin
						enq_pct = 55;
					end
				endcase
				left_in_burst = $urandom_range(40, 8);
			end
			left_in_burst--;
			send_item(($urandom_range(99) < enq_pct) ? spq_pkg::ACTION_ENQ : spq_pkg::ACTION_DEQ,
				VW'($urandom), pick_priority());
		end
	endtask

	initial begin
		// Reset is held from the start and released at a falling edge.
		repeat (3) @(negedge clk);
		arst_n        <= 1'b1;
		send_idle_pct <= 37;
		recv_idle_pct <= 81;
		@(negedge clk);

		// Directed part. A removal from the empty queue comes first.
		send_item(spq_pkg::ACTION_DEQ, '0, '0);
		// Field extremes and alternating bit patterns.
		send_item(spq_pkg::ACTION_ENQ, 8'h00, 16'h0000);
		send_item(spq_pkg::ACTION_ENQ, 8'hFF, 16'hFFFF);
		send_item(spq_pkg::ACTION_ENQ, 8'hA5, 16'h5A5A);
		send_item(spq_pkg::ACTION_ENQ, 8'h5A, 16'hA5A5);
		// Three entries of equal priority: the newest must leave first among them.
		for (int k = 1; k <= 3; k++)
			send_item(spq_pkg::ACTION_ENQ, VW'(k), 16'h1234);
		// Fill the queue to its depth, then try one more insert, which is refused
		// even though its priority would put it at the head.
		repeat (spq_pkg::DEPTH_DEF - 7)
			send_item(spq_pkg::ACTION_ENQ, VW'($urandom), PW'($urandom));
		send_item(spq_pkg::ACTION_ENQ, 8'hFF, 16'h0000);
		// Removals carry random payload fields, which the block must ignore.
		repeat (5)
			send_item(spq_pkg::ACTION_DEQ, VW'($urandom), PW'($urandom));

		// First random phase: sparse sender, heavily stalling receiver.
		send_random(260);

		// Second random phase: the idle rates swap sides.
		send_idle_pct <= 81;
		recv_idle_pct <= 37;
		send_random(270);

		// Back pressure: the receiver holds off while inserts keep coming with no gaps.
		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		hold_off_req  <= 1'b1;
		repeat (20)
			send_item(spq_pkg::ACTION_ENQ, VW'($urandom), pick_priority());

		// Last random phase with no idling on either side.
		send_random(280);
		in_valid <= 1'b0;

		// Drain every owed result, then keep clocking the block before the verdict so a
		// stray result would still be seen.
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
